@@ src/crb_pkg.sv @@
package crb_pkg;

	localparam int FRAC_W  = 20;
	localparam int WORD_W  = 24;
	localparam int RAD_W   = 23;
	localparam int DAMP_W  = 17;
	localparam int D2_W    = 2 * WORD_W;
	localparam int ROOT_W  = WORD_W;
	localparam int Q_W     = FRAC_W + 1;
	localparam int NUM_W   = WORD_W + FRAC_W;
	localparam int N_W     = Q_W + 1;
	localparam int PROD_W  = 48;
	localparam int DOT_W   = 26;
	localparam int KP_W    = 44;
	localparam int K_W     = 28;
	localparam int KN_W    = 52;
	localparam int K_SHIFT = 15;

	localparam logic [RAD_W-1:0]  BR_RESET   = RAD_W'(943718);
	localparam logic [RAD_W-1:0]  BALL_RESET = RAD_W'(10486);
	localparam logic [DAMP_W-1:0] DAMP_RESET = DAMP_W'(62259);

	typedef enum logic [1:0] {
		REG_BOUNDARY = 2'd0,
		REG_BALL     = 2'd1,
		REG_DAMPING  = 2'd2,
		REG_NONE     = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] vy;
		logic signed [WORD_W-1:0] vx;
		logic signed [WORD_W-1:0] y;
		logic signed [WORD_W-1:0] x;
	} item_t;

	// Shift right by s with rounding to nearest, halves away from zero.
	function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
		input int unsigned s);
		logic [63:0] mag;
		logic [63:0] r;
		mag = v[63] ? unsigned'(-v) : unsigned'(v);
		r = (mag + (64'd1 << (s - 1))) >> s;
		return v[63] ? -signed'(r) : signed'(r);
	endfunction

	function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (WORD_W - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (v > hi) begin
			return hi[WORD_W-1:0];
		end else if (v < lo) begin
			return lo[WORD_W-1:0];
		end
		return v[WORD_W-1:0];
	endfunction

endpackage

@@ src/crb_sqrt.sv @@
module crb_sqrt import crb_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [D2_W-1:0]   d2,
	output logic [ROOT_W-1:0] root
);

	logic [D2_W-1:0]   rem_q  [ROOT_W-1];
	logic [ROOT_W-1:0] root_q [ROOT_W];

	// One result bit per stage, most significant first; rem holds d2 minus root squared.
	for (genvar k = 0; k < ROOT_W; k++) begin : g_bit
		localparam int B = ROOT_W - 1 - k;
		logic [D2_W-1:0]   rem_in;
		logic [ROOT_W-1:0] r_in;
		logic [D2_W-1:0]   trial;
		logic              take;

		if (k == 0) begin : g_first
			assign rem_in = d2;
			assign r_in   = '0;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign r_in   = root_q[k-1];
		end

		assign trial = (D2_W'(r_in) << (B + 1)) + (D2_W'(1) << (2 * B));
		assign take  = rem_in >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				root_q[k] <= take ? (r_in | (ROOT_W'(1) << B)) : r_in;
			end
		end

		if (k < ROOT_W - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[k] <= take ? (rem_in - trial) : rem_in;
				end
			end
		end
	end

	assign root = root_q[ROOT_W-1];

endmodule

@@ src/crb_div.sv @@
module crb_div import crb_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [NUM_W-1:0]  num,
	input  logic [ROOT_W-1:0] den,
	output logic [Q_W-1:0]    quo
);

	logic [NUM_W-1:0]  rem_q [Q_W-1];
	logic [ROOT_W-1:0] den_q [Q_W-1];
	logic [Q_W-1:0]    quo_q [Q_W];

	// Restoring division, one quotient bit per stage; the quotient never exceeds Q_W bits.
	for (genvar k = 0; k < Q_W; k++) begin : g_bit
		localparam int B = Q_W - 1 - k;
		logic [NUM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] den_in;
		logic [Q_W-1:0]    q_in;
		logic [NUM_W-1:0]  sub;
		logic              take;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign q_in   = '0;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign den_in = den_q[k-1];
			assign q_in   = quo_q[k-1];
		end

		assign sub  = NUM_W'(den_in) << B;
		assign take = rem_in >= sub;

		always_ff @(posedge clk) begin
			if (en) begin
				quo_q[k] <= take ? (q_in | (Q_W'(1) << B)) : q_in;
			end
		end

		if (k < Q_W - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[k] <= take ? (rem_in - sub) : rem_in;
					den_q[k] <= den_in;
				end
			end
		end
	end

	assign quo = quo_q[Q_W-1];

endmodule

@@ src/circular_boundary_reflect.sv @@
// Channel   Direction  Handshake          Payload
// s_axis    in         s_tvalid/s_tready  s_tdata: pos_x, pos_y, vel_x, vel_y
// m_axis    out        m_tvalid/m_tready  m_tdata: new_pos_x..new_vel_y, m_tuser: hit
// cfg       in         cfg_valid/cfg_ready cfg_index, cfg_data
// One item enters per cycle while the output is not stalled; each result passes the squares,
// the sum, the 24-stage square root, the 21-stage dividers and the back-end stages in order.
// Reset clears the valid bits and loads the default radii and damping.
// When the output holds a result that is not taken, the whole pipeline stops
// and s_tready falls; nothing is dropped or repeated.
module circular_boundary_reflect import crb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [4*WORD_W-1:0] s_tdata,   // pos_x, pos_y, vel_x, vel_y
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [4*WORD_W-1:0] m_tdata,   // new_pos_x, new_pos_y, new_vel_x, new_vel_y
	output logic                m_tuser,   // hit
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [RAD_W-1:0]    cfg_data
);

	logic [RAD_W-1:0]  br_q;
	logic [RAD_W-1:0]  ball_q;
	logic [DAMP_W-1:0] damp_q;
	logic signed [WORD_W-1:0] lim;
	logic en;

	assign cfg_ready = 1'b1;
	assign lim = signed'({1'b0, br_q}) - signed'({1'b0, ball_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			br_q   <= BR_RESET;
			ball_q <= BALL_RESET;
			damp_q <= DAMP_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BOUNDARY: br_q   <= cfg_data;
				REG_BALL:     ball_q <= cfg_data;
				REG_DAMPING:  damp_q <= cfg_data[DAMP_W-1:0];
				REG_NONE:     ;
			endcase
		end
	end

	// Front: squares, then the sum.
	item_t it_in;
	item_t it_s1, it_s2, it_s3, it_s4, it_s5, it_s6, it_s7, it_s8, it_s9;
	logic signed [D2_W-1:0] xx_s1, yy_s1;
	logic [D2_W-1:0] d2_s2;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;

	assign it_in = item_t'(s_tdata);
	assign en = !v_s10 || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1 <= it_in;
			xx_s1 <= D2_W'(it_in.x) * D2_W'(it_in.x);
			yy_s1 <= D2_W'(it_in.y) * D2_W'(it_in.y);
			it_s2 <= it_s1;
			d2_s2 <= unsigned'(xx_s1) + unsigned'(yy_s1);
		end
	end

	// Square root, with the item and valid bit riding alongside.
	logic [ROOT_W-1:0] root;
	item_t it_sq [ROOT_W];
	logic  v_sq  [ROOT_W];

	crb_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.d2   (d2_s2),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			it_sq[0] <= it_s2;
			for (int i = 1; i < ROOT_W; i++) begin
				it_sq[i] <= it_sq[i-1];
			end
		end
	end

	// Divider inputs and the hit decision.
	logic [ROOT_W-1:0] dist_s3;
	logic [NUM_W-1:0]  numx_s3, numy_s3;
	logic              pass_s3;
	logic [WORD_W-1:0] magx, magy;

	assign magx = it_sq[ROOT_W-1].x[WORD_W-1] ? unsigned'(-it_sq[ROOT_W-1].x)
		: unsigned'(it_sq[ROOT_W-1].x);
	assign magy = it_sq[ROOT_W-1].y[WORD_W-1] ? unsigned'(-it_sq[ROOT_W-1].y)
		: unsigned'(it_sq[ROOT_W-1].y);

	always_ff @(posedge clk) begin
		if (en) begin
			it_s3   <= it_sq[ROOT_W-1];
			dist_s3 <= root;
			numx_s3 <= {magx, FRAC_W'(0)} + NUM_W'(root >> 1);
			numy_s3 <= {magy, FRAC_W'(0)} + NUM_W'(root >> 1);
			pass_s3 <= (root == '0) || (signed'({1'b0, root}) < signed'({lim[WORD_W-1], lim}));
		end
	end

	logic [Q_W-1:0] qx, qy;
	item_t it_dv   [Q_W];
	logic  pass_dv [Q_W];
	logic  v_dv    [Q_W];

	crb_div u_div_x (.clk(clk), .en(en), .num(numx_s3), .den(dist_s3), .quo(qx));
	crb_div u_div_y (.clk(clk), .en(en), .num(numy_s3), .den(dist_s3), .quo(qy));

	always_ff @(posedge clk) begin
		if (en) begin
			it_dv[0]   <= it_s3;
			pass_dv[0] <= pass_s3;
			for (int i = 1; i < Q_W; i++) begin
				it_dv[i]   <= it_dv[i-1];
				pass_dv[i] <= pass_dv[i-1];
			end
		end
	end

	// Back end: normal, dot product, damping, reflection.
	logic signed [N_W-1:0]    nx_s4, ny_s4, nx_s5, ny_s5, nx_s6, ny_s6;
	logic signed [N_W-1:0]    nx_s7, ny_s7, nx_s8, ny_s8;
	logic signed [PROD_W-1:0] pvx_s5, pvy_s5, plx_s5, ply_s5;
	logic signed [DOT_W-1:0]  dot_s6;
	logic signed [WORD_W-1:0] npx_s6, npy_s6, npx_s7, npy_s7, npx_s8, npy_s8;
	logic signed [WORD_W-1:0] npx_s9, npy_s9;
	logic signed [KP_W-1:0]   kp_s7;
	logic signed [K_W-1:0]    k_s8;
	logic signed [KN_W-1:0]   knx_s9, kny_s9;
	logic pass_s4, pass_s5, pass_s6, pass_s7, pass_s8, pass_s9;
	logic signed [N_W-1:0] qxs, qys;

	assign qxs = signed'({1'b0, qx});
	assign qys = signed'({1'b0, qy});

	always_ff @(posedge clk) begin
		if (en) begin
			it_s4   <= it_dv[Q_W-1];
			pass_s4 <= pass_dv[Q_W-1];
			nx_s4   <= it_dv[Q_W-1].x[WORD_W-1] ? -qxs : qxs;
			ny_s4   <= it_dv[Q_W-1].y[WORD_W-1] ? -qys : qys;

			it_s5 <= it_s4; pass_s5 <= pass_s4; nx_s5 <= nx_s4; ny_s5 <= ny_s4;
			pvx_s5 <= PROD_W'(it_s4.vx) * PROD_W'(nx_s4);
			pvy_s5 <= PROD_W'(it_s4.vy) * PROD_W'(ny_s4);
			plx_s5 <= PROD_W'(lim) * PROD_W'(nx_s4);
			ply_s5 <= PROD_W'(lim) * PROD_W'(ny_s4);

			it_s6 <= it_s5; pass_s6 <= pass_s5; nx_s6 <= nx_s5; ny_s6 <= ny_s5;
			dot_s6 <= DOT_W'(rshr(64'(pvx_s5) + 64'(pvy_s5), FRAC_W));
			npx_s6 <= sat_word(rshr(64'(plx_s5), FRAC_W));
			npy_s6 <= sat_word(rshr(64'(ply_s5), FRAC_W));

			it_s7 <= it_s6; pass_s7 <= pass_s6; nx_s7 <= nx_s6; ny_s7 <= ny_s6;
			npx_s7 <= npx_s6; npy_s7 <= npy_s6;
			kp_s7 <= KP_W'(dot_s6) * signed'(KP_W'(damp_q));

			it_s8 <= it_s7; pass_s8 <= pass_s7; nx_s8 <= nx_s7; ny_s8 <= ny_s7;
			npx_s8 <= npx_s7; npy_s8 <= npy_s7;
			k_s8 <= K_W'(rshr(64'(kp_s7), K_SHIFT));

			it_s9 <= it_s8; pass_s9 <= pass_s8; npx_s9 <= npx_s8; npy_s9 <= npy_s8;
			knx_s9 <= KN_W'(k_s8) * KN_W'(nx_s8);
			kny_s9 <= KN_W'(k_s8) * KN_W'(ny_s8);
		end
	end

	item_t out_item;
	logic  hit_s10;
	item_t res_s10;

	always_comb begin
		out_item.x  = npx_s9;
		out_item.y  = npy_s9;
		out_item.vx = sat_word(64'(it_s9.vx) - rshr(64'(knx_s9), FRAC_W));
		out_item.vy = sat_word(64'(it_s9.vy) - rshr(64'(kny_s9), FRAC_W));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s10 <= pass_s9 ? it_s9 : out_item;
			hit_s10 <= !pass_s9;
		end
	end

	// Valid bits follow the data through every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0;
			for (int i = 0; i < ROOT_W; i++) v_sq[i] <= 1'b0;
			for (int i = 0; i < Q_W; i++) v_dv[i] <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_sq[0] <= v_s2;
			for (int i = 1; i < ROOT_W; i++) v_sq[i] <= v_sq[i-1];
			v_s3 <= v_sq[ROOT_W-1];
			v_dv[0] <= v_s3;
			for (int i = 1; i < Q_W; i++) v_dv[i] <= v_dv[i-1];
			v_s4 <= v_dv[Q_W-1];
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7; v_s9 <= v_s8;
			v_s10 <= v_s9;
		end
	end

	assign m_tvalid = v_s10;
	assign m_tdata  = res_s10;
	assign m_tuser  = hit_s10;

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	a_zero_pass: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && (dist_s3 == '0) |-> pass_s3)
		else $error("zero distance item marked as hit");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("waiting result changed before it was taken");

	a_no_hit_inside: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !pass_s3 |-> dist_s3 != '0)
		else $error("hit decided with zero distance");

endmodule

@@ tb/tb.sv @@
module tb;
	import crb_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [4*WORD_W-1:0] s_tdata;   // pos_x, pos_y, vel_x, vel_y
	logic                m_tvalid;
	logic                m_tready;
	logic [4*WORD_W-1:0] m_tdata;   // new_pos_x, new_pos_y, new_vel_x, new_vel_y
	logic                m_tuser;   // hit
	logic                cfg_valid;
	logic                cfg_ready;
	logic [1:0]          cfg_index;
	logic [RAD_W-1:0]    cfg_data;

	bit quiet;
	bit hold_req;

	circular_boundary_reflect dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	typedef struct {
		logic [4*WORD_W-1:0] data;
		bit                  hit;
	} bounce_t;

	class reflect_board;
		logic [RAD_W-1:0]  boundary;
		logic [RAD_W-1:0]  ball;
		logic [DAMP_W-1:0] damp;
		bounce_t           pending[$];
		int                errors;

		function new();
			boundary = BR_RESET;
			ball = BALL_RESET;
			damp = DAMP_RESET;
			errors = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [RAD_W-1:0] val);
			case (idx)
				REG_BOUNDARY: boundary = val;
				REG_BALL:     ball = val;
				REG_DAMPING:  damp = val[DAMP_W-1:0];
				default: ;
			endcase
		endfunction

		function longint round_shift(longint v, int s);
			longint half;
			half = longint'(1) <<< (s - 1);
			if (v >= 0)
				return (v + half) >>> s;
			return -((-v + half) >>> s);
		endfunction

		function longint unsigned root(longint unsigned v);
			longint unsigned res;
			longint unsigned b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function longint unit_comp(longint num, longint unsigned den);
			longint unsigned mag;
			longint unsigned q;
			mag = (num < 0) ? longint'(-num) : longint'(num);
			q = ((mag << FRAC_W) + den / 2) / den;
			return (num < 0) ? -longint'(q) : longint'(q);
		endfunction

		function logic [WORD_W-1:0] clamp(longint v);
			longint hi;
			hi = (longint'(1) <<< (WORD_W - 1)) - 1;
			if (v > hi) v = hi;
			if (v < -hi - 1) v = -hi - 1;
			return v[WORD_W-1:0];
		endfunction

		function void note(logic [4*WORD_W-1:0] d);
			longint x, y, vx, vy, lim, nx, ny, dot, k;
			longint unsigned span;
			bounce_t e;
			x  = longint'(signed'(d[0*WORD_W +: WORD_W]));
			y  = longint'(signed'(d[1*WORD_W +: WORD_W]));
			vx = longint'(signed'(d[2*WORD_W +: WORD_W]));
			vy = longint'(signed'(d[3*WORD_W +: WORD_W]));
			lim = longint'(boundary) - longint'(ball);
			span = root(longint'(x * x + y * y));
			if (span == 0 || longint'(span) < lim) begin
				e.data = d;
				e.hit = 0;
			end else begin
				nx = unit_comp(x, span);
				ny = unit_comp(y, span);
				dot = round_shift(vx * nx + vy * ny, FRAC_W);
				k = round_shift(dot * longint'(damp), K_SHIFT);
				e.data = {clamp(vy - round_shift(k * ny, FRAC_W)),
					clamp(vx - round_shift(k * nx, FRAC_W)),
					clamp(round_shift(lim * ny, FRAC_W)),
					clamp(round_shift(lim * nx, FRAC_W))};
				e.hit = 1;
			end
			pending.push_back(e);
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check(logic [4*WORD_W-1:0] d, logic h);
			bounce_t e;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result %h hit %b", d, h));
				return;
			end
			e = pending.pop_front();
			for (int i = 0; i < 4; i++) begin
				if (d[i*WORD_W +: WORD_W] !== e.data[i*WORD_W +: WORD_W])
					report($sformatf("word %0d got %h want %h", i,
						d[i*WORD_W +: WORD_W], e.data[i*WORD_W +: WORD_W]));
			end
			if (h !== e.hit)
				report($sformatf("hit got %b want %b", h, e.hit));
		endtask
	endclass

	reflect_board board = new();

	initial clk = 0;
	always #10 clk = ~clk;

	// All three handshakes are observed here, at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				board.write_reg(cfg_reg_t'(cfg_index), cfg_data);
			if (s_tvalid && s_tready)
				board.note(s_tdata);
			if (m_tvalid && m_tready)
				board.check(m_tdata, m_tuser);
		end
	end

	// Receiver: random stall bursts, or one long hold-off on request.
	initial begin
		m_tready = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready = 0;
				for (int c = 0; c < 300; c++)
					@(negedge clk);
				hold_req = 0;
				m_tready = 1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				m_tready = 0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
				m_tready = 1;
			end else begin
				m_tready = 1;
			end
		end
	end

	function logic [WORD_W-1:0] rand_field();
		int r;
		if ($urandom_range(0, 2) == 0)
			return WORD_W'($urandom);
		r = 1 << $urandom_range(4, 23);
		return WORD_W'(int'($urandom % (2 * r)) - r);
	endfunction

	task send_item(logic [WORD_W-1:0] px, logic [WORD_W-1:0] py,
		logic [WORD_W-1:0] vx, logic [WORD_W-1:0] vy);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_tvalid = 0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		s_tdata = {vy, vx, py, px};
		s_tvalid = 1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		s_tvalid = 0;
	endtask

	task drain();
		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (70) @(negedge clk);
	endtask

	task write_cfg(cfg_reg_t idx, int unsigned val);
		cfg_index = idx;
		cfg_data = RAD_W'(val);
		cfg_valid = 1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task send_random(int n);
		logic [WORD_W-1:0] lim;
		lim = WORD_W'(board.boundary - board.ball);
		for (int i = 0; i < n; i++) begin
			// Half the items sit near the limit circle so the hit path is busy.
			if ($urandom_range(0, 1))
				send_item(lim + WORD_W'($urandom_range(0, 64)) - WORD_W'(32),
					WORD_W'($urandom_range(0, 2000)) - WORD_W'(1000),
					rand_field(), rand_field());
			else
				send_item(rand_field(), rand_field(), rand_field(), rand_field());
		end
	endtask

	localparam logic [WORD_W-1:0] WMAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic [WORD_W-1:0] WMIN = {1'b1, {(WORD_W-1){1'b0}}};

	initial begin
		int unsigned phases[6][3];
		logic [WORD_W-1:0] lim;
		phases = '{'{8388607, 0, 65536}, '{0, 0, 0}, '{100000, 8388607, 131071},
			'{8388607, 8388607, 1}, '{2000000, 5000, 100000}, '{943718, 10486, 62259}};
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		cfg_valid = 0;
		cfg_index = REG_BOUNDARY;
		cfg_data = '0;
		quiet = 0;
		hold_req = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed items with the reset configuration.
		lim = WORD_W'(BR_RESET - BALL_RESET);
		send_item('0, '0, WMAX, WMIN);
		send_item('0, '0, '0, '0);
		send_item(WMAX, WMAX, WMAX, WMAX);
		send_item(WMIN, WMIN, WMIN, WMIN);
		send_item(WMIN, '0, WMAX, WMIN);
		send_item('0, WMAX, WMIN, WMAX);
		send_item(lim, '0, 24'h100000, 24'h0);
		send_item(lim - WORD_W'(1), '0, 24'h100000, 24'h0);
		send_item('0, -lim, 24'h0, WMIN);
		send_item(24'h0a0000, 24'h0a0000, 24'hf00000, 24'h050000);
		send_item(WORD_W'(1), '0, WMAX, WMAX);
		send_item(24'h000001, 24'hffffff, 24'h7, 24'h3);
		send_item(24'h200000, 24'hfe0000, 24'h0, 24'h0);

		// Long receiver hold-off while items keep coming.
		hold_req = 1;
		send_random(150);
		drain();
		send_random(50);

		foreach (phases[p]) begin
			drain();
			write_cfg(REG_BOUNDARY, phases[p][0]);
			write_cfg(REG_BALL, phases[p][1]);
			write_cfg(REG_DAMPING, phases[p][2]);
			if (p == 5)
				quiet = 1;
			if (p == 1 || p == 2) begin
				// Zero or negative limit: every item with nonzero distance hits.
				send_item('0, '0, WMAX, WMAX);
				send_item(WORD_W'(1), '0, WMAX, WMIN);
				send_item(WMAX, WMIN, WMIN, WMAX);
			end
			send_random(160);
		end

		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (70) @(negedge clk);
		if (board.errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	initial begin
		#8000000;
		$display("tb failed");
		$finish;
	end

endmodule
